/* rtl/idsp_pkg.sv */
// Shared types and codes of the interrupt dispatcher.
package idsp_pkg;

    // Pending and mask vectors have a fixed width of nine lines
    localparam int PEND_W    = 9;
    localparam int CMD_W     = 4;
    localparam int LINE_W    = 4;
    localparam int KIND_W    = 2;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET_FAST     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SET_NORMAL   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_UNMASK_FAST  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_MASK_FAST    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_UNMASK_NORM  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MASK_NORM    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DISPATCH     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_READ_FAST    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_READ_NORMAL  = 4'd8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_FAST   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd3;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_KEEP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_KEEP = 1'd1;
    localparam logic [PEND_W-1:0]    FAST_KEEP_RST   = 9'h004;
    localparam logic [PEND_W-1:0]    NORMAL_KEEP_RST = 9'h000;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line;
        logic [DATA_W-1:0] call_address;
        logic [DATA_W-1:0] dispatch_count;
        logic [PEND_W-1:0] fast_clear;
        logic [PEND_W-1:0] normal_clear;
        logic [PEND_W-1:0] fast_mask_now;
        logic [PEND_W-1:0] normal_mask_now;
        logic              last;
    } t_result;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_REPLY = 4'b0010,
        S_PICK  = 4'b0100,
        S_EVAL  = 4'b1000
    } t_state;

endpackage

/* rtl/idsp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module idsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/idsp_seq.sv */
// Command sequencer: decodes commands, scans pending lines, read-modify-writes the line table.
module idsp_seq #(
    parameter int LINE_COUNT    = 9,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command item
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [idsp_pkg::CMD_W-1:0]         i_cmd,
    input  logic [idsp_pkg::LINE_W-1:0]        i_line,
    input  logic [idsp_pkg::DATA_W-1:0]        i_handler_address,
    input  logic [idsp_pkg::PEND_W-1:0]        i_fast_pending,
    input  logic [idsp_pkg::PEND_W-1:0]        i_normal_pending,
    // keep masks
    input  logic [idsp_pkg::PEND_W-1:0]        i_fast_keep,
    input  logic [idsp_pkg::PEND_W-1:0]        i_normal_keep,
    // result towards the output register
    input  logic                               i_out_free,
    output logic                               o_out_valid,
    output idsp_pkg::t_result                  o_out,
    // line table
    output logic                               o_rd_en,
    output logic [$clog2(2*LINE_COUNT)-1:0]    o_rd_addr,
    input  logic [ADDRESS_WIDTH+idsp_pkg::DATA_W-1:0] i_rd_data,
    output logic                               o_wr_en,
    output logic [$clog2(2*LINE_COUNT)-1:0]    o_wr_addr,
    output logic [ADDRESS_WIDTH+idsp_pkg::DATA_W-1:0] o_wr_data
);
    import idsp_pkg::*;

    localparam int DEPTH = 2 * LINE_COUNT;
    localparam int EW    = $clog2(DEPTH);
    localparam int XW    = LINE_COUNT + PEND_W;
    localparam int WW    = ADDRESS_WIDTH + DATA_W;
    localparam logic [PEND_W-1:0] FAST_MASK_RST = (LINE_COUNT > 3) ? 9'h008 : 9'h000;

    t_state                   r_state, n_state;
    logic [CMD_W-1:0]         r_cmd, n_cmd;
    logic [LINE_W-1:0]        r_line, n_line;
    logic [ADDRESS_WIDTH-1:0] r_h, n_h;
    logic [PEND_W-1:0]        r_fp, n_fp;
    logic [PEND_W-1:0]        r_np, n_np;
    logic [DEPTH-1:0]         r_todo, n_todo;
    logic [EW-1:0]            r_cur, n_cur;
    logic [PEND_W-1:0]        r_fmask, n_fmask;
    logic [PEND_W-1:0]        r_nmask, n_nmask;
    logic                     r_rd_ok, n_rd_ok;
    logic [DEPTH-1:0]         r_vld, n_vld;

    logic [XW-1:0]            fp_x, np_x;
    logic                     in_ok, in_sel, in_rd, ok_r, sel_r;
    logic [PEND_W-1:0]        mbit;
    logic [WW-1:0]            word;
    logic [ADDRESS_WIDTH-1:0] hdl;
    logic [DATA_W-1:0]        cnt;
    logic [EW-1:0]            pick;
    logic                     found;

    assign fp_x   = XW'(i_fast_pending);
    assign np_x   = XW'(i_normal_pending);
    assign in_ok  = (32'(i_line) < LINE_COUNT);
    assign in_sel = (i_cmd == CMD_SET_NORMAL) || (i_cmd == CMD_READ_NORMAL);
    assign in_rd  = in_ok && ((i_cmd == CMD_SET_FAST) || (i_cmd == CMD_SET_NORMAL) ||
                              (i_cmd == CMD_READ_FAST) || (i_cmd == CMD_READ_NORMAL));
    assign ok_r   = (32'(r_line) < LINE_COUNT);
    assign sel_r  = (r_cmd == CMD_SET_NORMAL) || (r_cmd == CMD_READ_NORMAL);
    assign mbit   = (ok_r && (32'(r_line) < PEND_W)) ? (9'd1 << r_line) : 9'd0;
    // entries never written read as zero
    assign word   = r_rd_ok ? i_rd_data : '0;
    assign hdl    = word[ADDRESS_WIDTH-1:0];
    assign cnt    = word[WW-1:ADDRESS_WIDTH];
    assign o_ready = (r_state == S_IDLE);

    // lowest remaining entry: fast before normal within a line
    always_comb begin
        pick  = '0;
        found = 1'b0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (r_todo[k]) begin
                pick  = EW'(k);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_line      = r_line;
        n_h         = r_h;
        n_fp        = r_fp;
        n_np        = r_np;
        n_todo      = r_todo;
        n_cur       = r_cur;
        n_fmask     = r_fmask;
        n_nmask     = r_nmask;
        n_rd_ok     = r_rd_ok;
        n_vld       = r_vld;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = '0;
        o_out_valid = 1'b0;
        o_out       = '0;
        o_out.fast_mask_now   = r_fmask;
        o_out.normal_mask_now = r_nmask;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd  = i_cmd;
                    n_line = i_line;
                    n_h    = ADDRESS_WIDTH'(i_handler_address);
                    n_fp   = i_fast_pending;
                    n_np   = i_normal_pending;
                    for (int i = 0; i < LINE_COUNT; i++) begin
                        n_todo[2*i]   = fp_x[i];
                        n_todo[2*i+1] = np_x[i];
                    end
                    o_rd_en   = in_rd;
                    o_rd_addr = EW'({i_line, in_sel});
                    n_rd_ok   = in_rd && r_vld[o_rd_addr];
                    n_state   = (i_cmd == CMD_DISPATCH) ? S_PICK : S_REPLY;
                end
            end
            S_REPLY: begin
                if (i_out_free) begin
                    o_out.kind = KIND_REPLY;
                    o_out.line = r_line;
                    o_out.last = 1'b1;
                    case (r_cmd)
                        CMD_SET_FAST, CMD_SET_NORMAL: begin
                            if (ok_r) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = EW'({r_line, sel_r});
                                o_wr_data = {cnt, r_h};
                                n_vld[o_wr_addr] = 1'b1;
                                o_out.call_address = DATA_W'(r_h);
                                if (sel_r) begin
                                    n_nmask = r_nmask & ~mbit;
                                end else begin
                                    n_fmask = r_fmask & ~mbit;
                                end
                            end
                        end
                        CMD_UNMASK_FAST: n_fmask = r_fmask & ~mbit;
                        CMD_MASK_FAST:   n_fmask = r_fmask | mbit;
                        CMD_UNMASK_NORM: n_nmask = r_nmask & ~mbit;
                        CMD_MASK_NORM:   n_nmask = r_nmask | mbit;
                        CMD_READ_FAST, CMD_READ_NORMAL: begin
                            if (ok_r) begin
                                o_out.call_address   = DATA_W'(hdl);
                                o_out.dispatch_count = cnt;
                            end
                        end
                        default: o_out.line = '0;
                    endcase
                    o_out.fast_mask_now   = n_fmask;
                    o_out.normal_mask_now = n_nmask;
                    o_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_PICK: begin
                if (found) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = pick;
                    n_rd_ok   = r_vld[pick];
                    n_cur     = pick;
                    n_todo[pick] = 1'b0;
                    n_state   = S_EVAL;
                end else if (i_out_free) begin
                    o_out.kind         = KIND_CLEAR;
                    o_out.fast_clear   = r_fp & ~i_fast_keep;
                    o_out.normal_clear = r_np & ~i_normal_keep;
                    o_out.last         = 1'b1;
                    o_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_EVAL: begin
                if (hdl == '0) begin
                    n_state = S_PICK;
                end else if (i_out_free) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_cur;
                    o_wr_data = {cnt + 32'd1, hdl};
                    o_out.kind           = r_cur[0] ? KIND_NORMAL : KIND_FAST;
                    o_out.line           = LINE_W'(r_cur >> 1);
                    o_out.call_address   = DATA_W'(hdl | ADDRESS_WIDTH'(1));
                    o_out.dispatch_count = cnt + 32'd1;
                    o_out_valid          = 1'b1;
                    n_state              = S_PICK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fmask <= FAST_MASK_RST;
            r_nmask <= '0;
            r_vld   <= '0;
            r_todo  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fmask <= n_fmask;
            r_nmask <= n_nmask;
            r_vld   <= n_vld;
            r_todo  <= n_todo;
            r_rd_ok <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_line <= n_line;
        r_h    <= n_h;
        r_fp   <= n_fp;
        r_np   <= n_np;
        r_cur  <= n_cur;
    end

endmodule

/* rtl/interrupt_dispatcher.sv */
// Top level of the vectored interrupt dispatcher.
//
// Keeps a handler address and a wrapping 32-bit dispatch count for each fast and each
// normal interrupt line in one line table RAM (entry = line * 2 + normal), with the two
// line masks in flip-flops. Each command item on the slave stream gives exactly one reply
// item (kind 3), except dispatch, which gives one call item per pending line with a nonzero
// handler (ascending line, fast before normal) followed by one clear-vector item carrying
// tlast. A command holds the input from its acceptance until it is finished. A non-dispatch
// command reads the table as it is accepted and enters its reply into the output register
// from the reply state. A dispatch passes each pending entry (up to 18 with nine lines)
// through a pick state, which reads the table, and an evaluate state, which evaluates the
// entry and also writes back the count for a call; the clear-vector item enters the output
// register from the pick state once no entry is left. A finished result that finds the
// output register still full waits in its state until the register is free.
// Entries never written read as zero by way of per-entry valid bits cleared at reset, so
// no clearing pass is needed. One output register parts the result side: a new command is
// taken while a result waits. The user writes keep masks through the configuration channel
// only while the block is idle; the block itself does not enforce this.
module interrupt_dispatcher #(
    parameter int LINE_COUNT    = 9,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: line[3:0], handler_address[35:4], fast_pending[44:36], normal_pending[53:45]
    input  logic [55:0]                       i_s_tdata,
    // tuser: cmd[3:0]
    input  logic [idsp_pkg::CMD_W-1:0]        i_s_tuser,
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: out_line[3:0], call_address[35:4], dispatch_count[67:36], fast_clear[76:68],
    //        normal_clear[85:77], fast_mask_now[94:86], normal_mask_now[103:95]
    output logic [103:0]                      o_m_tdata,
    // tuser: kind[1:0]
    output logic [idsp_pkg::KIND_W-1:0]       o_m_tuser,
    output logic                              o_m_tlast,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [idsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [idsp_pkg::PEND_W-1:0]       i_cfg_data
);
    import idsp_pkg::*;

    localparam int DEPTH = 2 * LINE_COUNT;
    localparam int EW    = $clog2(DEPTH);
    localparam int WW    = ADDRESS_WIDTH + DATA_W;

    logic [PEND_W-1:0] r_fast_keep;
    logic [PEND_W-1:0] r_normal_keep;
    logic              r_m_valid, n_m_valid;
    t_result           r_m;

    logic              seq_out_valid;
    t_result           seq_out;
    logic              out_free;
    logic              rd_en, wr_en;
    logic [EW-1:0]     rd_addr, wr_addr;
    logic [WW-1:0]     rd_data, wr_data;

    // Configuration: always ready, writes beyond the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_keep   <= FAST_KEEP_RST;
            r_normal_keep <= NORMAL_KEEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FAST_KEEP:   r_fast_keep   <= i_cfg_data;
                CFG_NORMAL_KEEP: r_normal_keep <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output register: free once empty or being taken this cycle
    assign out_free = !r_m_valid || i_m_tready;

    idsp_seq #(
        .LINE_COUNT    (LINE_COUNT),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_tvalid),
        .o_ready           (o_s_tready),
        .i_cmd             (i_s_tuser),
        .i_line            (i_s_tdata[3:0]),
        .i_handler_address (i_s_tdata[35:4]),
        .i_fast_pending    (i_s_tdata[44:36]),
        .i_normal_pending  (i_s_tdata[53:45]),
        .i_fast_keep       (r_fast_keep),
        .i_normal_keep     (r_normal_keep),
        .i_out_free        (out_free),
        .o_out_valid       (seq_out_valid),
        .o_out             (seq_out),
        .o_rd_en           (rd_en),
        .o_rd_addr         (rd_addr),
        .i_rd_data         (rd_data),
        .o_wr_en           (wr_en),
        .o_wr_addr         (wr_addr),
        .o_wr_data         (wr_data)
    );

    // Line table: {count, handler} per entry
    idsp_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Load a new result only when the register is free; hold it until taken
    always_comb begin
        n_m_valid = r_m_valid;
        if (seq_out_valid) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_out_valid) begin
            r_m <= seq_out;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m.kind;
    assign o_m_tlast  = r_m.last;
    assign o_m_tdata  = {r_m.normal_mask_now, r_m.fast_mask_now, r_m.normal_clear,
                         r_m.fast_clear, r_m.dispatch_count, r_m.call_address, r_m.line};

    // A handler call is never the final item of a command
    a_call_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser == KIND_FAST) || (o_m_tuser == KIND_NORMAL))
        |-> !o_m_tlast)
        else $error("handler call marked last");

    // Replies and clear vectors always close their command
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser == KIND_REPLY) || (o_m_tuser == KIND_CLEAR))
        |-> o_m_tlast)
        else $error("reply or clear vector without last");

    // Calls carry the handler with bit 0 set
    a_call_bit0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser == KIND_FAST) || (o_m_tuser == KIND_NORMAL))
        |-> o_m_tdata[4])
        else $error("handler call without bit 0 set");

    // One command at a time: no item is taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("command accepted while the previous one is in progress");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the vectored interrupt dispatcher.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idsp_pkg::*;

    localparam int LINE_COUNT    = 9;
    localparam int ADDRESS_WIDTH = 32;
    // Cycles without any accepted item before the run is abandoned
    localparam int IDLE_LIMIT    = 5000;
    // Quiet cycles after the last result before a keep mask write or the end
    localparam int SETTLE_CYCLES = 6;
    localparam int END_CYCLES    = 40;
    // Command codes past the last defined one
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = CMD_READ_NORMAL + CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = '1;
    localparam logic [LINE_W-1:0] LINE_TOP      = '1;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [55:0]          i_s_tdata   = '0;
    logic [CMD_W-1:0]     i_s_tuser   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [103:0]         o_m_tdata;
    logic [KIND_W-1:0]    o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PEND_W-1:0]    i_cfg_data  = '0;

    interrupt_dispatcher #(
        .LINE_COUNT    (LINE_COUNT),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: handler table, dispatch counts, masks, keep masks
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] fast_handler_tbl   [LINE_COUNT];
    logic [DATA_W-1:0] normal_handler_tbl [LINE_COUNT];
    logic [DATA_W-1:0] fast_count_tbl     [LINE_COUNT];
    logic [DATA_W-1:0] normal_count_tbl   [LINE_COUNT];
    logic [PEND_W-1:0] fast_mask_m;
    logic [PEND_W-1:0] normal_mask_m;
    logic [PEND_W-1:0] fast_keep_m;
    logic [PEND_W-1:0] normal_keep_m;

    // Results owed by the block, oldest first
    t_result awaited_results[$];

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int calls_seen    = 0;
    int keep_writes   = 0;
    int dispatches    = 0;

    // Idling controls shared by the sender and the receiver
    bit gaps_on = 1'b1;
    int rx_hold = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Bring the predictor to its state after reset
    task automatic reset_predictor();
        for (int i = 0; i < LINE_COUNT; i++) begin
            fast_handler_tbl[i]   = '0;
            normal_handler_tbl[i] = '0;
            fast_count_tbl[i]     = '0;
            normal_count_tbl[i]   = '0;
        end
        fast_mask_m   = 9'h008;
        normal_mask_m = '0;
        fast_keep_m   = FAST_KEEP_RST;
        normal_keep_m = NORMAL_KEEP_RST;
    endtask

    // Build one result; the masks always reflect the state after the command
    function automatic t_result make_result(logic [KIND_W-1:0] kind, logic [LINE_W-1:0] ln,
                                            logic [DATA_W-1:0] addr, logic [DATA_W-1:0] cnt,
                                            logic [PEND_W-1:0] fc, logic [PEND_W-1:0] nc,
                                            logic last);
        t_result r;
        r.kind            = kind;
        r.line            = ln;
        r.call_address    = addr;
        r.dispatch_count  = cnt;
        r.fast_clear      = fc;
        r.normal_clear    = nc;
        r.fast_mask_now   = fast_mask_m;
        r.normal_mask_now = normal_mask_m;
        r.last            = last;
        return r;
    endfunction

    // Work out the results of one accepted command and queue them
    task automatic predict_dispatcher(input logic [CMD_W-1:0] cmd, input logic [LINE_W-1:0] ln,
                                      input logic [DATA_W-1:0] addr,
                                      input logic [PEND_W-1:0] fp, input logic [PEND_W-1:0] np);
        logic              in_range;
        logic [PEND_W-1:0] sel;
        logic [DATA_W-1:0] reply_addr;
        logic [DATA_W-1:0] reply_count;
        logic [LINE_W-1:0] reply_line;
        in_range    = (ln < LINE_COUNT);
        sel         = in_range ? (PEND_W'(1) << ln) : '0;
        reply_addr  = '0;
        reply_count = '0;
        reply_line  = ln;
        if (cmd == CMD_DISPATCH) begin
            // Scan ascending, fast before normal; lines without a handler stay silent
            for (int i = 0; i < LINE_COUNT; i++) begin
                if (fp[i] && fast_handler_tbl[i] != '0) begin
                    fast_count_tbl[i] = fast_count_tbl[i] + 1;
                    awaited_results.push_back(make_result(KIND_FAST, LINE_W'(i),
                        fast_handler_tbl[i] | 32'd1, fast_count_tbl[i], '0, '0, 1'b0));
                end
                if (np[i] && normal_handler_tbl[i] != '0) begin
                    normal_count_tbl[i] = normal_count_tbl[i] + 1;
                    awaited_results.push_back(make_result(KIND_NORMAL, LINE_W'(i),
                        normal_handler_tbl[i] | 32'd1, normal_count_tbl[i], '0, '0, 1'b0));
                end
            end
            awaited_results.push_back(make_result(KIND_CLEAR, '0, '0, '0,
                fp & ~fast_keep_m, np & ~normal_keep_m, 1'b1));
            return;
        end
        case (cmd)
            CMD_SET_FAST: begin
                if (in_range) begin
                    fast_handler_tbl[ln] = addr;
                    fast_mask_m          = fast_mask_m & ~sel;
                    reply_addr           = addr;
                end
            end
            CMD_SET_NORMAL: begin
                if (in_range) begin
                    normal_handler_tbl[ln] = addr;
                    normal_mask_m          = normal_mask_m & ~sel;
                    reply_addr             = addr;
                end
            end
            CMD_UNMASK_FAST: fast_mask_m   = fast_mask_m & ~sel;
            CMD_MASK_FAST:   fast_mask_m   = fast_mask_m | sel;
            CMD_UNMASK_NORM: normal_mask_m = normal_mask_m & ~sel;
            CMD_MASK_NORM:   normal_mask_m = normal_mask_m | sel;
            CMD_READ_FAST: begin
                if (in_range) begin
                    reply_addr  = fast_handler_tbl[ln];
                    reply_count = fast_count_tbl[ln];
                end
            end
            CMD_READ_NORMAL: begin
                if (in_range) begin
                    reply_addr  = normal_handler_tbl[ln];
                    reply_count = normal_count_tbl[ln];
                end
            end
            default: reply_line = '0;
        endcase
        awaited_results.push_back(make_result(KIND_REPLY, reply_line, reply_addr, reply_count,
                                              '0, '0, 1'b1));
    endtask

    // Gap length: mostly none, sometimes short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one command item, wait for the handshake, then predict its results
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [LINE_W-1:0] ln,
                             input logic [DATA_W-1:0] addr,
                             input logic [PEND_W-1:0] fp, input logic [PEND_W-1:0] np);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, np, fp, addr, ln};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        predict_dispatcher(cmd, ln, addr, fp, np);
        items_sent++;
        if (cmd == CMD_DISPATCH)
            dispatches++;
    endtask

    // Drop valid and wait until every owed result has come back, then idle for settle more cycles
    task automatic wait_idle(input int settle);
        i_s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write one keep mask while the block is idle
    task automatic write_keep(input logic [CFG_IDX_W-1:0] idx, input logic [PEND_W-1:0] val);
        wait_idle(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FAST_KEEP)
            fast_keep_m = val;
        else
            normal_keep_m = val;
        keep_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Read back untouched lines: zero handlers and counts, reset masks in every reply
    task automatic test_reset_reads();
        send_item(CMD_READ_FAST,   4'd0, '0, '0, '0);
        send_item(CMD_READ_FAST,   4'd3, '0, '0, '0);
        send_item(CMD_READ_NORMAL, 4'd8, '0, '0, '0);
    endtask

    // Handler registration, mask commands, out-of-range lines and unknown codes
    task automatic test_line_commands();
        send_item(CMD_SET_FAST,    4'd0, 32'hFFFF_FFFF, '0, '0);
        send_item(CMD_SET_NORMAL,  4'd8, 32'h0000_0000, '0, '0);
        send_item(CMD_SET_FAST,    4'd8, 32'hAAAA_5554, '1, '1);
        send_item(CMD_SET_NORMAL,  4'd0, 32'h1234_5678, '0, '0);
        send_item(CMD_SET_FAST,    4'd3, 32'h5555_5555, '0, '0);
        send_item(CMD_MASK_FAST,   4'd3, '0, '0, '0);
        send_item(CMD_UNMASK_FAST, 4'd3, '0, '0, '0);
        send_item(CMD_MASK_NORM,   4'd8, '0, '0, '0);
        send_item(CMD_UNMASK_NORM, 4'd8, '0, '0, '0);
        // Lines past the table change nothing and reply with zeros
        send_item(CMD_SET_FAST,    4'd9, 32'hDEAD_BEEF, '0, '0);
        send_item(CMD_READ_NORMAL, LINE_TOP, '0, '0, '0);
        send_item(CMD_MASK_NORM,   4'd12, '0, '0, '0);
        send_item(CMD_UNKNOWN_LO,  4'd5, 32'hFFFF_FFFF, '1, '1);
        send_item(CMD_UNKNOWN_HI,  LINE_TOP, 32'hFFFF_FFFF, '1, '1);
    endtask

    // Dispatch with nothing pending, with only handler-less lines, and with everything
    task automatic test_dispatch_cases();
        send_item(CMD_DISPATCH,    4'd0, '0, 9'h000, 9'h000);
        send_item(CMD_DISPATCH,    4'd0, '0, 9'h002, 9'h100);
        send_item(CMD_DISPATCH,    LINE_TOP, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF);
        send_item(CMD_READ_FAST,   4'd0, '0, '0, '0);
        send_item(CMD_READ_NORMAL, 4'd0, '0, '0, '0);
    endtask

    // Set the keep masks to their extremes, to random values and back to reset, each pair followed by a dispatch
    task automatic test_keep_masks();
        write_keep(CFG_FAST_KEEP, '0);
        write_keep(CFG_NORMAL_KEEP, '1);
        send_item(CMD_DISPATCH, 4'd0, '0, 9'h1FF, 9'h1FF);
        write_keep(CFG_FAST_KEEP, '1);
        write_keep(CFG_NORMAL_KEEP, '0);
        send_item(CMD_DISPATCH, 4'd0, '0, 9'h1FF, 9'h1FF);
        write_keep(CFG_FAST_KEEP, PEND_W'($urandom_range(0, 511)));
        write_keep(CFG_NORMAL_KEEP, PEND_W'($urandom_range(0, 511)));
        send_item(CMD_DISPATCH, 4'd0, '0, 9'h1FF, PEND_W'($urandom_range(0, 511)));
        write_keep(CFG_FAST_KEEP, FAST_KEEP_RST);
        write_keep(CFG_NORMAL_KEEP, NORMAL_KEEP_RST);
        send_item(CMD_DISPATCH, 4'd0, '0, PEND_W'($urandom_range(0, 511)), 9'h1FF);
    endtask

    // Fill every handler, hold the receiver off and keep offering full dispatches
    task automatic test_backpressure();
        for (int i = 0; i < LINE_COUNT; i++) begin
            send_item(CMD_SET_FAST,   LINE_W'(i), $urandom | 32'h100, '0, '0);
            send_item(CMD_SET_NORMAL, LINE_W'(i), $urandom | 32'h100, '0, '0);
        end
        wait_idle(SETTLE_CYCLES);
        gaps_on = 1'b0;
        rx_hold = 300;
        repeat (10)
            send_item(CMD_DISPATCH, 4'd0, '0, 9'h1FF, 9'h1FF);
        wait_idle(SETTLE_CYCLES);
        gaps_on = 1'b1;
    endtask

    // Mostly valid commands on valid lines, with dispatch favoured; the rest is noise
    task automatic send_random_item();
        logic [CMD_W-1:0]  cmd;
        logic [LINE_W-1:0] ln;
        logic [DATA_W-1:0] addr;
        logic [PEND_W-1:0] fp;
        logic [PEND_W-1:0] np;
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)      cmd = CMD_SET_FAST;
        else if (r < 24) cmd = CMD_SET_NORMAL;
        else if (r < 29) cmd = CMD_UNMASK_FAST;
        else if (r < 34) cmd = CMD_MASK_FAST;
        else if (r < 38) cmd = CMD_UNMASK_NORM;
        else if (r < 42) cmd = CMD_MASK_NORM;
        else if (r < 72) cmd = CMD_DISPATCH;
        else if (r < 81) cmd = CMD_READ_FAST;
        else if (r < 90) cmd = CMD_READ_NORMAL;
        else             cmd = CMD_UNKNOWN_LO + CMD_W'($urandom_range(0, 6));
        ln = ($urandom_range(0, 9) != 0) ? LINE_W'($urandom_range(0, LINE_COUNT - 1))
                                         : LINE_W'($urandom_range(LINE_COUNT, 15));
        r = $urandom_range(0, 99);
        if (r < 10)      addr = '0;
        else if (r < 15) addr = '1;
        else             addr = $urandom;
        fp = ($urandom_range(0, 7) == 0) ? '0 : PEND_W'($urandom_range(0, 511));
        np = ($urandom_range(0, 7) == 0) ? '0 : PEND_W'($urandom_range(0, 511));
        send_item(cmd, ln, addr, fp, np);
    endtask

    // Random phases with fresh keep masks in between; one phase runs without idling
    task automatic test_random();
        for (int phase = 0; phase < 4; phase++) begin
            write_keep(CFG_FAST_KEEP, PEND_W'($urandom_range(0, 511)));
            write_keep(CFG_NORMAL_KEEP, PEND_W'($urandom_range(0, 511)));
            gaps_on = (phase != 2);
            repeat (70)
                send_random_item();
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off when a test asks for one
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_m_tready <= 1'b0;
                rx_hold--;
            end else if (!gaps_on) begin
                i_m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest owed one
    // ------------------------------------------------------------------
    task automatic report_field(input string name, input logic [DATA_W-1:0] exp_v,
                                input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind            = o_m_tuser;
            got.line            = o_m_tdata[3:0];
            got.call_address    = o_m_tdata[35:4];
            got.dispatch_count  = o_m_tdata[67:36];
            got.fast_clear      = o_m_tdata[76:68];
            got.normal_clear    = o_m_tdata[85:77];
            got.fast_mask_now   = o_m_tdata[94:86];
            got.normal_mask_now = o_m_tdata[103:95];
            got.last            = o_m_tlast;
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d line %0d",
                         $time, got.kind, got.line);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (want.kind == KIND_FAST || want.kind == KIND_NORMAL)
                    calls_seen++;
                report_field("kind", DATA_W'(want.kind), DATA_W'(got.kind));
                report_field("out_line", DATA_W'(want.line), DATA_W'(got.line));
                report_field("call_address",    want.call_address,    got.call_address);
                report_field("dispatch_count",  want.dispatch_count,  got.dispatch_count);
                report_field("fast_clear", DATA_W'(want.fast_clear), DATA_W'(got.fast_clear));
                report_field("normal_clear", DATA_W'(want.normal_clear),
                             DATA_W'(got.normal_clear));
                report_field("fast_mask_now", DATA_W'(want.fast_mask_now),
                             DATA_W'(got.fast_mask_now));
                report_field("normal_mask_now", DATA_W'(want.normal_mask_now),
                             DATA_W'(got.normal_mask_now));
                report_field("last", DATA_W'(want.last), DATA_W'(got.last));
            end
        end
    end

    // Watchdog: count cycles in which no item moves on any channel
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results still owed", $time, awaited_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_predictor();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_reads();
        test_line_commands();
        test_dispatch_cases();
        test_keep_masks();
        test_backpressure();
        test_random();

        wait_idle(END_CYCLES);
        if (awaited_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            error_count++;
        end
        $display("Run covered %0d commands (%0d dispatches) and %0d keep mask writes,",
                 items_sent, dispatches, keep_writes);
        $display("checking %0d results of which %0d were handler calls.",
                 results_seen, calls_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
